### rtl/core/fmh_pkg.sv
// Package for the MurmurHash2 stream block: hash constants, operation codes
// and the work entry that runs from the front end through the queue to the back end.
// Depends on nothing.
package fmh_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'hFFFFFFFB;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PART,
		OP_FULL
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] k;
		logic [31:0] init;
		logic        first;
		logic        last;
	} entry_t;

endpackage

### rtl/core/fmh_front.sv
// Front end: accepts input beats, drops beats outside a message, classifies
// each word and premixes full words in three stages. Uses fmh_pkg.
module fmh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         hash_seed,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         data_word,
	input  logic [2:0]          byte_count,
	input  logic                first_word,
	input  logic                last_word,
	input  logic [31:0]         message_length,
	output logic                push,
	output fmh_pkg::entry_t     push_entry,
	input  logic                q_full
);

	logic            in_msg_q;
	logic            v_s1, v_s2, v_s3;
	fmh_pkg::entry_t e_s1, e_s2, e_s3;
	fmh_pkg::entry_t e_in;
	fmh_pkg::entry_t e_s1_mix, e_s2_mix;
	logic            adv, accept, keep;
	logic [31:0]     prod1, prod2;
	logic [31:0]     k2_fold;

	assign adv      = !v_s3 || !q_full;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign keep     = first_word || in_msg_q;
	assign push     = v_s3 && !q_full;
	assign push_entry = e_s3;

	always_comb begin
		e_in.init  = hash_seed ^ message_length;
		e_in.first = first_word;
		e_in.last  = last_word;
		case (byte_count)
			3'd0: begin
				e_in.op = fmh_pkg::OP_NONE;
				e_in.k  = data_word;
			end
			3'd1: begin
				e_in.op = fmh_pkg::OP_PART;
				e_in.k  = data_word & 32'h0000_00FF;
			end
			3'd2: begin
				e_in.op = fmh_pkg::OP_PART;
				e_in.k  = data_word & 32'h0000_FFFF;
			end
			3'd3: begin
				e_in.op = fmh_pkg::OP_PART;
				e_in.k  = data_word & 32'h00FF_FFFF;
			end
			default: begin
				e_in.op = fmh_pkg::OP_FULL;
				e_in.k  = data_word;
			end
		endcase
	end

	assign prod1   = e_s1.k * fmh_pkg::MIX_MUL;
	assign k2_fold = e_s2.k ^ (e_s2.k >> fmh_pkg::MIX_SHIFT);
	assign prod2   = k2_fold * fmh_pkg::MIX_MUL;

	always_comb begin
		e_s1_mix = e_s1;
		if (e_s1.op == fmh_pkg::OP_FULL) begin
			e_s1_mix.k = prod1;
		end
		e_s2_mix = e_s2;
		if (e_s2.op == fmh_pkg::OP_FULL) begin
			e_s2_mix.k = prod2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (accept && keep) begin
				in_msg_q <= !last_word;
			end
			if (adv) begin
				v_s1 <= accept && keep;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= e_in;
			e_s2 <= e_s1_mix;
			e_s3 <= e_s2_mix;
		end
	end

endmodule

### rtl/core/fmh_queue.sv
// Short queue of work entries between the front end and the back end.
// Uses fmh_pkg for the entry type.
module fmh_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fmh_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output fmh_pkg::entry_t pop_entry,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fmh_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### rtl/core/fmh_back.sv
// Back end: folds each queued entry into the running hash, then runs the
// final avalanche through a_s1 and m_s2 into the output register hash_q. Uses fmh_pkg.
module fmh_back (
	input  logic            clk,
	input  logic            arst_n,
	output logic            pop,
	input  fmh_pkg::entry_t pop_entry,
	input  logic            q_empty,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     hash_value
);

	logic [31:0] h_q;
	logic [31:0] hb, mul_in, hn;
	logic [31:0] prod_h, prod_a;
	logic        en;
	logic        va_s1, va_s2, out_valid_q;
	logic [31:0] a_s1, m_s2, hash_q;

	assign en  = !(out_valid_q && out_stall);
	assign pop = en && !q_empty;

	assign hb     = pop_entry.first ? pop_entry.init : h_q;
	assign mul_in = (pop_entry.op == fmh_pkg::OP_FULL) ? hb : (hb ^ pop_entry.k);
	assign prod_h = mul_in * fmh_pkg::MIX_MUL;
	assign prod_a = a_s1 * fmh_pkg::MIX_MUL;

	always_comb begin
		unique case (pop_entry.op)
			fmh_pkg::OP_FULL: hn = prod_h ^ pop_entry.k;
			fmh_pkg::OP_PART: hn = prod_h;
			default:          hn = hb;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= '0;
			va_s1       <= 1'b0;
			va_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (pop) begin
				h_q <= hn;
			end
			va_s1       <= pop && pop_entry.last;
			va_s2       <= va_s1;
			out_valid_q <= va_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= hn ^ (hn >> fmh_pkg::FIN_SHIFT_A);
			m_s2   <= prod_a;
			hash_q <= m_s2 ^ (m_s2 >> fmh_pkg::FIN_SHIFT_B);
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

### rtl/core/murmurhash2_stream.sv
// MurmurHash2 (32-bit) over a stream of little-endian words.
// The last beat passes front stages s1 to s3, the queue, then a_s1, m_s2 and hash_q in fmh_back.
// Throughput: one input beat per cycle unless stalled; fmh_back's one-multiply hash loop sets it.
// A stalled output holds the back end; the queue then fills and stalls the input.
// Reset is asynchronous: seed returns to 0xFFFFFFFB, no message is open, queue is empty.
module murmurhash2_stream #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [31:0] message_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);

	logic [31:0]     seed_q;
	logic            push, pop, q_full, q_empty;
	fmh_pkg::entry_t push_entry, pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= fmh_pkg::SEED_RESET;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	fmh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.hash_seed      (seed_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.first_word     (first_word),
		.last_word      (last_word),
		.message_length (message_length),
		.push           (push),
		.push_entry     (push_entry),
		.q_full         (q_full)
	);

	fmh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	fmh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_empty    (q_empty),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule

### rtl/core/fmh_checker.sv
// Port-level checker for murmurhash2_stream, attached by the bind below.
// Depends only on the top-level ports.
module fmh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        first_word,
	input logic        last_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] hash_value
);

	logic       open_q;
	logic [7:0] pending_q;
	logic       take_last, out_beat;

	assign take_last = in_valid && !in_stall && last_word && (first_word || open_q);
	assign out_beat  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			pending_q <= '0;
		end else begin
			if (in_valid && !in_stall && (first_word || open_q)) begin
				open_q <= !last_word;
			end
			if (take_last && !out_beat) begin
				pending_q <= pending_q + 8'd1;
			end else if (out_beat && !take_last) begin
				pending_q <= pending_q - 8'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result beat dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_value))
		else $error("Stalled hash changed.");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("Hash beat without a finished message.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("Input stalled while the output side was free.");

endmodule

bind murmurhash2_stream fmh_checker u_fmh_checker (.*);
